// ----- hw/rtl/ece_pkg.sv -----
package ece_pkg;

    // number formats
    localparam int FRAC_W       = 15;
    localparam int ONE          = 1 << FRAC_W;
    localparam int HALF_ONE     = ONE / 2;
    localparam int PROG_W       = FRAC_W + 1;
    localparam int EASED_W      = FRAC_W + 2;
    localparam int SINE_ENTRIES = 1024;
    localparam int EXP2_ENTRIES = 256;
    localparam int SIN_IDX_W    = $clog2(SINE_ENTRIES);
    localparam int SINQ_W       = SIN_IDX_W - 2;
    localparam int SINQ_ENTRIES = SINE_ENTRIES / 4 + 1;
    localparam int EXP2_IDX_W   = $clog2(EXP2_ENTRIES);
    // phase numerator is pre-shifted so only a divide by 3 or 9 remains
    localparam int PHASE_SHIFT  = FRAC_W - SIN_IDX_W + 2;

    localparam longint Q30      = 64'sd1 << 30;
    localparam longint LN2_Q30  = 64'sd744261118;
    localparam longint HPI_Q30  = 64'sd1686629713;

    // back curve constants
    localparam int C1   = int'((64'sd170158 * ONE + 64'sd50000) / 64'sd100000);
    localparam int C3   = C1 + ONE;
    localparam int C2   = int'((64'sd259490950 * ONE + 64'sd50000000) / 64'sd100000000);
    localparam int C2P1 = C2 + ONE;

    // curve codes
    localparam logic [3:0] CURVE_LINEAR        = 4'd0;
    localparam logic [3:0] CURVE_CUBIC_IN      = 4'd1;
    localparam logic [3:0] CURVE_CUBIC_OUT     = 4'd2;
    localparam logic [3:0] CURVE_CUBIC_INOUT   = 4'd3;
    localparam logic [3:0] CURVE_ELASTIC_IN    = 4'd4;
    localparam logic [3:0] CURVE_ELASTIC_OUT   = 4'd5;
    localparam logic [3:0] CURVE_ELASTIC_INOUT = 4'd6;
    localparam logic [3:0] CURVE_QUAD_IN       = 4'd7;
    localparam logic [3:0] CURVE_QUAD_OUT      = 4'd8;
    localparam logic [3:0] CURVE_QUAD_INOUT    = 4'd9;
    localparam logic [3:0] CURVE_BACK_IN       = 4'd10;
    localparam logic [3:0] CURVE_BACK_OUT      = 4'd11;
    localparam logic [3:0] CURVE_BACK_INOUT    = 4'd12;
    localparam logic [3:0] CURVE_BOUNCE_OUT    = 4'd13;
    localparam logic [3:0] CURVE_BOUNCE_IN     = 4'd14;
    localparam logic [3:0] CURVE_BOUNCE_INOUT  = 4'd15;

    typedef logic [FRAC_W+1:0] t_exp2_tab [EXP2_ENTRIES];
    typedef logic [FRAC_W+1:0] t_sinq_tab [SINQ_ENTRIES];

    // 2^(-i/N) from a series of exp(-i*ln2/N) in Q30
    function automatic t_exp2_tab f_build_exp2();
        t_exp2_tab tab;
        longint    y;
        longint    term;
        longint    sum;
        for (int i = 0; i < EXP2_ENTRIES; i++) begin
            y    = longint'(i) * LN2_Q30 / EXP2_ENTRIES;
            term = Q30;
            sum  = Q30;
            // series terms one to fifteen
            term = -(term * y) / (Q30 * 1);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 2);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 3);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 4);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 5);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 6);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 7);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 8);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 9);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 10);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 11);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 12);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 13);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 14);
            sum  = sum + term;
            term = -(term * y) / (Q30 * 15);
            sum  = sum + term;
            if (sum < 0) sum = 0;
            tab[i] = (FRAC_W+2)'((sum + (64'sd1 <<< (29 - FRAC_W))) >>> (30 - FRAC_W));
        end
        return tab;
    endfunction

    // quarter wave of sine, one entry per full-table step
    function automatic t_sinq_tab f_build_sinq();
        t_sinq_tab tab;
        longint    phi;
        longint    term;
        longint    sum;
        longint    t1;
        for (int j = 0; j < SINQ_ENTRIES; j++) begin
            phi  = longint'(4 * j) * HPI_Q30 / SINE_ENTRIES;
            term = phi;
            sum  = phi;
            // odd series terms three to twenty-one
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 2 * 3);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 4 * 5);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 6 * 7);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 8 * 9);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 10 * 11);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 12 * 13);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 14 * 15);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 16 * 17);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 18 * 19);
            sum  = sum + term;
            t1   = (term * phi) / Q30;
            term = -(t1 * phi) / (Q30 * 20 * 21);
            sum  = sum + term;
            if (sum < 0) sum = 0;
            if (sum > Q30) sum = Q30;
            tab[j] = (FRAC_W+2)'((sum + (64'sd1 <<< (29 - FRAC_W))) >>> (30 - FRAC_W));
        end
        return tab;
    endfunction

    localparam t_exp2_tab EXP2_TAB = f_build_exp2();
    localparam t_sinq_tab SINQ_TAB = f_build_sinq();

    // rounded fixed point product
    function automatic logic signed [24:0] f_fmul(input logic signed [19:0] a,
                                                  input logic signed [19:0] b);
        logic signed [39:0] p;
        p = a * b;
        return 25'((p + 40'(HALF_ONE)) >>> FRAC_W);
    endfunction

    function automatic logic signed [21:0] f_halve(input logic signed [21:0] v);
        return (v + 22'sd1) >>> 1;
    endfunction

    // stage words
    typedef struct packed {
        logic [PROG_W-1:0]   f;
        logic                low;
        logic                f_zero;
        logic                f_one;
        logic signed [17:0]  x;
        logic [18:0]         e;
        logic [15:0]         sin_y;
        logic                div9;
        logic signed [18:0]  bd;
        logic [1:0]          bpiece;
    } t_s1;

    typedef struct packed {
        logic [PROG_W-1:0]     f;
        logic                  low;
        logic                  f_zero;
        logic                  f_one;
        logic signed [17:0]    x;
        logic signed [17:0]    sq;
        logic signed [18:0]    p12;
        logic [34:0]           dd;
        logic [1:0]            bpiece;
        logic [SIN_IDX_W-1:0]  sidx;
        logic [FRAC_W+1:0]     pexp;
        logic [3:0]            k;
    } t_s2;

    typedef struct packed {
        logic [PROG_W-1:0]   f;
        logic                low;
        logic                f_zero;
        logic                f_one;
        logic signed [17:0]  sq;
        logic signed [17:0]  cube;
        logic signed [17:0]  c1s;
        logic signed [19:0]  t12;
        logic [FRAC_W+1:0]   bnc;
        logic signed [17:0]  sinv;
        logic [FRAC_W+1:0]   pw;
    } t_s3;

    typedef struct packed {
        logic [PROG_W-1:0]   f;
        logic                low;
        logic                f_zero;
        logic                f_one;
        logic signed [17:0]  sq;
        logic signed [17:0]  cube;
        logic signed [17:0]  c1s;
        logic signed [18:0]  c3c;
        logic signed [17:0]  ep;
        logic signed [19:0]  b12;
        logic [FRAC_W+1:0]   bnc;
    } t_s4;

endpackage

// ----- hw/rtl/ece_if.sv -----
// progress word channel
interface ece_progress_if;
    logic                        valid;
    logic                        ready;
    logic [ece_pkg::PROG_W-1:0]  progress;
    modport source (output valid, output progress, input ready);
    modport sink (input valid, input progress, output ready);
endinterface

// eased value word channel
interface ece_eased_if;
    logic                               valid;
    logic                               ready;
    logic signed [ece_pkg::EASED_W-1:0] eased_value;
    modport source (output valid, output eased_value, input ready);
    modport sink (input valid, input eased_value, output ready);
endinterface

// ----- hw/rtl/easing_curve_evaluator.sv -----
// Easing curve evaluator: maps an unsigned Q1.15 progress word (values above 1.0 are
// taken as 1.0) through the curve chosen by curve_select and returns a saturated
// signed Q2.15 eased value. It takes one word per cycle unless the input is held, and holds
// five words in flight in five register stages (operand setup, squares and table reads,
// cubes and sine, second products, final form and output register). A stalled output lets
// bubbles ahead of it fill before the input is held. curve_select should be written only
// while no word is in flight.
module easing_curve_evaluator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    ece_progress_if.sink  i_prog,
    ece_eased_if.source   o_eased
);

    localparam int STAGES = 5;

    logic [3:0]         r_curve_select;
    logic [STAGES-1:0]  r_v;
    logic [STAGES-1:0]  n_v;
    logic [STAGES:0]    adv;

    ece_pkg::t_s1 s1;
    ece_pkg::t_s4 s4;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_select <= ece_pkg::CURVE_LINEAR;
        end else if (i_cfg_we) begin
            r_curve_select <= i_cfg_wdata;
        end
    end

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        adv[STAGES] = o_eased.ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
        n_v = r_v;
        if (adv[0]) begin
            n_v[0] = i_prog.valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_prog.ready  = adv[0];
    assign o_eased.valid = r_v[STAGES-1];

    ece_front u_front (
        .i_clk      (i_clk),
        .i_en       (adv[0]),
        .i_sel      (r_curve_select),
        .i_progress (i_prog.progress),
        .o_s1       (s1)
    );

    ece_arith u_arith (
        .i_clk (i_clk),
        .i_en  (adv[3:1]),
        .i_s1  (s1),
        .o_s4  (s4)
    );

    ece_combine u_combine (
        .i_clk   (i_clk),
        .i_en    (adv[4]),
        .i_sel   (r_curve_select),
        .i_s4    (s4),
        .o_eased (o_eased.eased_value)
    );

`ifndef SYNTHESIS
    // input held back only when every stage holds a word
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_prog.ready |-> (r_v == {STAGES{1'b1}}))
        else $error("input blocked with a bubble in the pipeline");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_prog.valid && i_prog.ready) |=> r_v[0])
        else $error("accepted word lost at first stage");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_eased.valid)
        else $error("output valid right after reset");
`endif

endmodule

// ----- hw/rtl/ece_front.sv -----
module ece_front (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [3:0]                 i_sel,
    input  logic [ece_pkg::PROG_W-1:0] i_progress,
    output ece_pkg::t_s1               o_s1
);

    localparam logic signed [23:0] K_ONE = 24'(ece_pkg::ONE);

    ece_pkg::t_s1 r_s1;
    ece_pkg::t_s1 n_s1;

    logic [ece_pkg::PROG_W-1:0] f;
    logic                       low;
    logic signed [23:0]         fs;
    logic signed [23:0]         xv;
    logic signed [23:0]         ev;
    logic signed [23:0]         num;
    logic signed [23:0]         bx;
    logic signed [23:0]         t;
    logic signed [23:0]         dv;
    logic [1:0]                 piece;
    logic                       div9;

    always_comb begin
        // clamp to one
        f   = (i_progress > ece_pkg::PROG_W'(ece_pkg::ONE)) ?
              ece_pkg::PROG_W'(ece_pkg::ONE) : i_progress;
        fs  = $signed(24'(f));
        low = (f < ece_pkg::PROG_W'(ece_pkg::HALF_ONE));

        // polynomial operand
        xv = '0;
        unique case (i_sel) inside
            ece_pkg::CURVE_CUBIC_IN, ece_pkg::CURVE_QUAD_IN, ece_pkg::CURVE_BACK_IN: begin
                xv = fs;
            end
            ece_pkg::CURVE_CUBIC_OUT, ece_pkg::CURVE_QUAD_OUT: begin
                xv = K_ONE - fs;
            end
            ece_pkg::CURVE_CUBIC_INOUT, ece_pkg::CURVE_QUAD_INOUT: begin
                xv = low ? fs : (K_ONE <<< 1) - (fs <<< 1);
            end
            ece_pkg::CURVE_BACK_OUT: begin
                xv = fs - K_ONE;
            end
            ece_pkg::CURVE_BACK_INOUT: begin
                xv = low ? (fs <<< 1) : (fs <<< 1) - (K_ONE <<< 1);
            end
            default: xv = '0;
        endcase

        // elastic exponent and phase, phase offset by whole turns to stay positive
        ev   = '0;
        num  = '0;
        div9 = 1'b0;
        unique case (i_sel)
            ece_pkg::CURVE_ELASTIC_IN: begin
                ev  = (K_ONE - fs) * 24'sd10;
                num = fs * 24'sd40 + K_ONE * 24'sd5;
            end
            ece_pkg::CURVE_ELASTIC_OUT: begin
                ev  = fs * 24'sd10;
                num = fs * 24'sd40 + K_ONE * 24'sd9;
            end
            ece_pkg::CURVE_ELASTIC_INOUT: begin
                ev   = low ? K_ONE * 24'sd10 - fs * 24'sd20 : fs * 24'sd20 - K_ONE * 24'sd10;
                num  = fs * 24'sd160 + K_ONE * 24'sd19;
                div9 = 1'b1;
            end
            default: begin
                ev  = '0;
                num = '0;
            end
        endcase

        // bounce argument and piece
        bx = '0;
        unique case (i_sel)
            ece_pkg::CURVE_BOUNCE_OUT:   bx = fs;
            ece_pkg::CURVE_BOUNCE_IN:    bx = K_ONE - fs;
            ece_pkg::CURVE_BOUNCE_INOUT: bx = low ? K_ONE - (fs <<< 1) : (fs <<< 1) - K_ONE;
            default:                     bx = '0;
        endcase
        t = bx * 24'sd11;
        if (t < K_ONE * 24'sd4) begin
            piece = 2'd0;
            dv    = t;
        end else if (t < K_ONE * 24'sd8) begin
            piece = 2'd1;
            dv    = t - K_ONE * 24'sd6;
        end else if (t < K_ONE * 24'sd10) begin
            piece = 2'd2;
            dv    = t - K_ONE * 24'sd9;
        end else begin
            piece = 2'd3;
            dv    = (t <<< 1) - K_ONE * 24'sd21;
        end

        n_s1.f      = f;
        n_s1.low    = low;
        n_s1.f_zero = (f == '0);
        n_s1.f_one  = (f == ece_pkg::PROG_W'(ece_pkg::ONE));
        n_s1.x      = 18'(xv);
        n_s1.e      = 19'(ev);
        n_s1.sin_y  = 16'(num >>> ece_pkg::PHASE_SHIFT);
        n_s1.div9   = div9;
        n_s1.bd     = 19'(dv);
        n_s1.bpiece = piece;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ----- hw/rtl/ece_arith.sv -----
module ece_arith (
    input  logic         i_clk,
    input  logic [2:0]   i_en,
    input  ece_pkg::t_s1 i_s1,
    output ece_pkg::t_s4 o_s4
);

    localparam logic signed [19:0] K_C1   = 20'(ece_pkg::C1);
    localparam logic signed [19:0] K_C3   = 20'(ece_pkg::C3);
    localparam logic signed [19:0] K_C2   = 20'(ece_pkg::C2);
    localparam logic signed [19:0] K_C2P1 = 20'(ece_pkg::C2P1);
    localparam int                 FW     = ece_pkg::FRAC_W;
    localparam logic [ece_pkg::SINQ_W:0] K_QTR = (ece_pkg::SINQ_W+1)'(ece_pkg::SINE_ENTRIES / 4);
    localparam logic [FW+1:0]      K_B1   = (FW+2)'(3 * ece_pkg::ONE / 4);
    localparam logic [FW+1:0]      K_B2   = (FW+2)'(15 * ece_pkg::ONE / 16);
    localparam logic [FW+1:0]      K_B3   = (FW+2)'(63 * ece_pkg::ONE / 64);

    ece_pkg::t_s2 r_s2;
    ece_pkg::t_s2 n_s2;
    ece_pkg::t_s3 r_s3;
    ece_pkg::t_s3 n_s3;
    ece_pkg::t_s4 r_s4;
    ece_pkg::t_s4 n_s4;

    logic signed [37:0]             dsq;
    logic [31:0]                    q3;
    logic [31:0]                    q9;
    logic [1:0]                     quad;
    logic [ece_pkg::SINQ_W-1:0]     jq;
    logic [ece_pkg::SINQ_W:0]       mq;
    logic [FW+1:0]                  sq_mag;
    logic [FW+2:0]                  pw_sum;

    // stage 2: squares, phase divide, exp2 lookup
    always_comb begin
        n_s2.f      = i_s1.f;
        n_s2.low    = i_s1.low;
        n_s2.f_zero = i_s1.f_zero;
        n_s2.f_one  = i_s1.f_one;
        n_s2.x      = i_s1.x;
        n_s2.sq     = 18'(ece_pkg::f_fmul(20'(i_s1.x), 20'(i_s1.x)));
        n_s2.p12    = 19'(ece_pkg::f_fmul(K_C2P1, 20'(i_s1.x)));
        dsq         = i_s1.bd * i_s1.bd;
        n_s2.dd     = 35'(dsq);
        n_s2.bpiece = i_s1.bpiece;
        q3          = (32'(i_s1.sin_y) * 32'd43691) >> 17;
        q9          = (32'(i_s1.sin_y) * 32'd58255) >> 19;
        n_s2.sidx   = i_s1.div9 ? q9[ece_pkg::SIN_IDX_W-1:0] : q3[ece_pkg::SIN_IDX_W-1:0];
        n_s2.pexp   = ece_pkg::EXP2_TAB[i_s1.e[FW-1 -: ece_pkg::EXP2_IDX_W]];
        n_s2.k      = 4'(i_s1.e >> FW);
    end

    // stage 3: cube, back terms, bounce, sine lookup, exp2 shift
    always_comb begin
        n_s3.f      = r_s2.f;
        n_s3.low    = r_s2.low;
        n_s3.f_zero = r_s2.f_zero;
        n_s3.f_one  = r_s2.f_one;
        n_s3.sq     = r_s2.sq;
        n_s3.cube   = 18'(ece_pkg::f_fmul(20'(r_s2.sq), 20'(r_s2.x)));
        n_s3.c1s    = 18'(ece_pkg::f_fmul(K_C1, 20'(r_s2.sq)));
        n_s3.t12    = r_s2.low ? 20'(r_s2.p12) - K_C2 : 20'(r_s2.p12) + K_C2;
        case (r_s2.bpiece)
            2'd0: n_s3.bnc = (FW+2)'((36'(r_s2.dd) + (36'd1 << (FW + 3))) >> (FW + 4));
            2'd1: n_s3.bnc = (FW+2)'((36'(r_s2.dd) + (36'd1 << (FW + 3))) >> (FW + 4))
                             + K_B1;
            2'd2: n_s3.bnc = (FW+2)'((36'(r_s2.dd) + (36'd1 << (FW + 3))) >> (FW + 4))
                             + K_B2;
            default: n_s3.bnc = (FW+2)'((36'(r_s2.dd) + (36'd1 << (FW + 5))) >> (FW + 6))
                                + K_B3;
        endcase
        // quarter wave symmetry
        quad   = r_s2.sidx[ece_pkg::SIN_IDX_W-1 -: 2];
        jq     = r_s2.sidx[ece_pkg::SINQ_W-1:0];
        mq     = quad[0] ? K_QTR - {1'b0, jq} : {1'b0, jq};
        sq_mag = ece_pkg::SINQ_TAB[mq];
        n_s3.sinv = quad[1] ? -$signed(18'(sq_mag)) : $signed(18'(sq_mag));
        // rounding right shift by the integer part of the exponent
        pw_sum  = (FW+3)'(r_s2.pexp) + (((FW+3)'(1) << r_s2.k) >> 1);
        n_s3.pw = (FW+2)'(pw_sum >> r_s2.k);
    end

    // stage 4: second products
    always_comb begin
        n_s4.f      = r_s3.f;
        n_s4.low    = r_s3.low;
        n_s4.f_zero = r_s3.f_zero;
        n_s4.f_one  = r_s3.f_one;
        n_s4.sq     = r_s3.sq;
        n_s4.cube   = r_s3.cube;
        n_s4.c1s    = r_s3.c1s;
        n_s4.c3c    = 19'(ece_pkg::f_fmul(K_C3, 20'(r_s3.cube)));
        n_s4.ep     = 18'(ece_pkg::f_fmul($signed(20'(r_s3.pw)), 20'(r_s3.sinv)));
        n_s4.b12    = 20'(ece_pkg::f_fmul(20'(r_s3.sq), r_s3.t12));
        n_s4.bnc    = r_s3.bnc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s2 <= n_s2;
        end
        if (i_en[1]) begin
            r_s3 <= n_s3;
        end
        if (i_en[2]) begin
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;

endmodule

// ----- hw/rtl/ece_combine.sv -----
module ece_combine (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [3:0]                         i_sel,
    input  ece_pkg::t_s4                       i_s4,
    output logic signed [ece_pkg::EASED_W-1:0] o_eased
);

    localparam logic signed [21:0] K_ONE = 22'(ece_pkg::ONE);
    localparam logic signed [21:0] K_MAX = 22'(2 * ece_pkg::ONE - 1);
    localparam logic signed [21:0] K_MIN = -22'(2 * ece_pkg::ONE);

    logic signed [ece_pkg::EASED_W-1:0] r_eased;
    logic signed [ece_pkg::EASED_W-1:0] n_eased;

    logic signed [21:0] fv;
    logic signed [21:0] c;
    logic signed [21:0] s;
    logic signed [21:0] ep;
    logic signed [21:0] b;
    logic signed [21:0] c3c;
    logic signed [21:0] c1s;
    logic signed [21:0] b12;
    logic signed [21:0] v;
    logic               low;

    always_comb begin
        fv  = $signed(22'(i_s4.f));
        c   = 22'(i_s4.cube);
        s   = 22'(i_s4.sq);
        ep  = 22'(i_s4.ep);
        b   = $signed(22'(i_s4.bnc));
        c3c = 22'(i_s4.c3c);
        c1s = 22'(i_s4.c1s);
        b12 = 22'(i_s4.b12);
        low = i_s4.low;

        // final form per curve
        unique case (i_sel)
            ece_pkg::CURVE_LINEAR:        v = fv;
            ece_pkg::CURVE_CUBIC_IN:      v = c;
            ece_pkg::CURVE_CUBIC_OUT:     v = K_ONE - c;
            ece_pkg::CURVE_CUBIC_INOUT:   v = low ? (c <<< 2) : K_ONE - ece_pkg::f_halve(c);
            ece_pkg::CURVE_ELASTIC_IN:    v = -ep;
            ece_pkg::CURVE_ELASTIC_OUT:   v = ep + K_ONE;
            ece_pkg::CURVE_ELASTIC_INOUT: v = low ? -ece_pkg::f_halve(ep)
                                                  : ece_pkg::f_halve(ep) + K_ONE;
            ece_pkg::CURVE_QUAD_IN:       v = s;
            ece_pkg::CURVE_QUAD_OUT:      v = K_ONE - s;
            ece_pkg::CURVE_QUAD_INOUT:    v = low ? (s <<< 1) : K_ONE - ece_pkg::f_halve(s);
            ece_pkg::CURVE_BACK_IN:       v = c3c - c1s;
            ece_pkg::CURVE_BACK_OUT:      v = K_ONE + c3c + c1s;
            ece_pkg::CURVE_BACK_INOUT:    v = low ? ece_pkg::f_halve(b12)
                                                  : ece_pkg::f_halve(b12 + (K_ONE <<< 1));
            ece_pkg::CURVE_BOUNCE_OUT:    v = b;
            ece_pkg::CURVE_BOUNCE_IN:     v = K_ONE - b;
            ece_pkg::CURVE_BOUNCE_INOUT:  v = low ? ece_pkg::f_halve(K_ONE - b)
                                                  : ece_pkg::f_halve(K_ONE + b);
            default:                      v = fv;
        endcase

        // elastic end points are exact
        if (i_sel == ece_pkg::CURVE_ELASTIC_IN || i_sel == ece_pkg::CURVE_ELASTIC_OUT ||
            i_sel == ece_pkg::CURVE_ELASTIC_INOUT) begin
            if (i_s4.f_zero) begin
                v = '0;
            end else if (i_s4.f_one) begin
                v = K_ONE;
            end
        end

        // saturate
        if (v < K_MIN) begin
            n_eased = ece_pkg::EASED_W'(K_MIN);
        end else if (v > K_MAX) begin
            n_eased = ece_pkg::EASED_W'(K_MAX);
        end else begin
            n_eased = ece_pkg::EASED_W'(v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_eased <= n_eased;
        end
    end

    assign o_eased = r_eased;

endmodule

// ----- verif/tb_easing_curve_evaluator.sv -----
module tb_easing_curve_evaluator;
    import ece_pkg::*;

    // fixed point easing predictor and store of pending eased words
    class eased_scoreboard;
        longint    exp2_lut [EXP2_ENTRIES];
        longint    sine_lut [SINE_ENTRIES];
        logic [3:0] curve;
        longint    pending_eased [$];
        int        errors;

        function new();
            longint y, term, sum, phi, t1, m, v;
            int q, rem;
            errors = 0;
            curve  = CURVE_LINEAR;
            // power of two table from a series in Q30
            for (int i = 0; i < EXP2_ENTRIES; i++) begin
                y    = longint'(i) * LN2_Q30 / EXP2_ENTRIES;
                term = Q30;
                sum  = Q30;
                for (int n = 1; n <= 15; n++) begin
                    term = -(term * y) / (longint'(n) * Q30);
                    sum += term;
                end
                if (sum < 0) sum = 0;
                exp2_lut[i] = q30_to_q(sum);
            end
            // full sine table from quarter wave symmetry
            for (int i = 0; i < SINE_ENTRIES; i++) begin
                q   = (4 * i) / SINE_ENTRIES;
                rem = (4 * i) % SINE_ENTRIES;
                m   = (q & 1) ? SINE_ENTRIES - rem : rem;
                phi  = m * HPI_Q30 / SINE_ENTRIES;
                term = phi;
                sum  = phi;
                for (longint n = 1; n <= 10; n++) begin
                    t1   = (term * phi) / Q30;
                    term = -(t1 * phi) / (Q30 * (2 * n) * (2 * n + 1));
                    sum += term;
                end
                if (sum < 0) sum = 0;
                if (sum > Q30) sum = Q30;
                v = q30_to_q(sum);
                sine_lut[i] = (q >= 2) ? -v : v;
            end
        endfunction

        function longint q30_to_q(longint v);
            return (v + (longint'(1) <<< (29 - FRAC_W))) >>> (30 - FRAC_W);
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b + ONE / 2) >>> FRAC_W;
        endfunction

        function longint half(longint x);
            return (x + 1) >>> 1;
        endfunction

        function longint cub(longint x);
            return qmul(qmul(x, x), x);
        endfunction

        // sine at num / (den * ONE) turns
        function longint sine_turns(longint num, longint den);
            longint a, b, idx;
            a = num * SINE_ENTRIES;
            b = den * ONE;
            idx = a / b;
            if ((a % b) != 0 && a < 0) idx--;
            idx = idx % SINE_ENTRIES;
            if (idx < 0) idx += SINE_ENTRIES;
            return sine_lut[idx];
        endfunction

        function longint pow2_down(longint e);
            longint k, r, v;
            k = e >>> FRAC_W;
            r = e & (ONE - 1);
            v = exp2_lut[(r * EXP2_ENTRIES) >>> FRAC_W];
            if (k > 0) v = (v + (longint'(1) <<< (k - 1))) >>> k;
            return v;
        endfunction

        function longint urdiv(longint a, longint b);
            return (a + b / 2) / b;
        endfunction

        function longint bounce(longint x);
            longint d;
            if (11 * x < 4 * ONE) begin
                d = 11 * x;
                return urdiv(d * d, 16 * ONE);
            end
            if (11 * x < 8 * ONE) begin
                d = 11 * x - 6 * ONE;
                return urdiv(d * d, 16 * ONE) + 3 * ONE / 4;
            end
            if (11 * x < 10 * ONE) begin
                d = 11 * x - 9 * ONE;
                return urdiv(d * d, 16 * ONE) + 15 * ONE / 16;
            end
            d = 22 * x - 21 * ONE;
            return urdiv(d * d, 64 * ONE) + 63 * ONE / 64;
        endfunction

        function longint ease(longint f);
            longint c1, c2, c3, v;
            bit lo;
            c1 = (longint'(170158) * ONE + 50000) / 100000;
            c3 = c1 + ONE;
            c2 = (longint'(259490950) * ONE + 50000000) / 100000000;
            lo = (2 * f < ONE);
            case (curve)
                CURVE_CUBIC_IN:    return cub(f);
                CURVE_CUBIC_OUT:   return ONE - cub(ONE - f);
                CURVE_CUBIC_INOUT: return lo ? 4 * cub(f) : ONE - half(cub(2 * ONE - 2 * f));
                CURVE_ELASTIC_IN, CURVE_ELASTIC_OUT, CURVE_ELASTIC_INOUT: begin
                    if (f == 0) return 0;
                    if (f == ONE) return ONE;
                    if (curve == CURVE_ELASTIC_IN)
                        return -qmul(pow2_down(10 * (ONE - f)), sine_turns(40 * f - 43 * ONE, 12));
                    if (curve == CURVE_ELASTIC_OUT)
                        return qmul(pow2_down(10 * f), sine_turns(40 * f - 3 * ONE, 12)) + ONE;
                    if (lo)
                        return -half(qmul(pow2_down(10 * ONE - 20 * f),
                                          sine_turns(160 * f - 89 * ONE, 36)));
                    return half(qmul(pow2_down(20 * f - 10 * ONE),
                                     sine_turns(160 * f - 89 * ONE, 36))) + ONE;
                end
                CURVE_QUAD_IN:    return qmul(f, f);
                CURVE_QUAD_OUT:   return ONE - qmul(ONE - f, ONE - f);
                CURVE_QUAD_INOUT: begin
                    v = 2 * ONE - 2 * f;
                    return lo ? 2 * qmul(f, f) : ONE - half(qmul(v, v));
                end
                CURVE_BACK_IN: return qmul(c3, cub(f)) - qmul(c1, qmul(f, f));
                CURVE_BACK_OUT: begin
                    v = f - ONE;
                    return ONE + qmul(c3, cub(v)) + qmul(c1, qmul(v, v));
                end
                CURVE_BACK_INOUT: begin
                    if (lo) begin
                        v = 2 * f;
                        return half(qmul(qmul(v, v), qmul(c2 + ONE, v) - c2));
                    end
                    v = 2 * f - 2 * ONE;
                    return half(qmul(qmul(v, v), qmul(c2 + ONE, v) + c2) + 2 * ONE);
                end
                CURVE_BOUNCE_OUT: return bounce(f);
                CURVE_BOUNCE_IN:  return ONE - bounce(ONE - f);
                CURVE_BOUNCE_INOUT: begin
                    if (lo) return half(ONE - bounce(ONE - 2 * f));
                    return half(ONE + bounce(2 * f - ONE));
                end
                default: return f;
            endcase
        endfunction

        // accepted progress word: queue its eased value
        function void note_progress(logic [PROG_W-1:0] p);
            longint f, v;
            f = p;
            if (f > ONE) f = ONE;
            v = ease(f);
            if (v < -2 * ONE) v = -2 * ONE;
            if (v > 2 * ONE - 1) v = 2 * ONE - 1;
            pending_eased.push_back(v);
        endfunction

        // accepted eased word: compare with oldest pending
        function void check_eased(logic signed [EASED_W-1:0] got);
            logic signed [EASED_W-1:0] want;
            if (pending_eased.size() == 0) begin
                $display("%0t: unexpected eased word, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = EASED_W'(pending_eased.pop_front());
            if (got !== want) begin
                $display("%0t: eased mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [3:0] i_cfg_wdata;

    ece_progress_if prog_if ();
    ece_eased_if    eased_if ();

    easing_curve_evaluator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_prog      (prog_if),
        .o_eased     (eased_if)
    );

    eased_scoreboard sb = new();
    bit quiet_sides;
    bit long_hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // output word check
    always @(posedge i_clk) begin
        if (i_rst_n && eased_if.valid && eased_if.ready)
            sb.check_eased(eased_if.eased_value);
    end

    // output ready with random stalls and one long hold
    initial begin
        int w;
        eased_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                eased_if.ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                w = quiet_sides ? 0 : $urandom_range(0, 7);
                if (w > 0) begin
                    eased_if.ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
                eased_if.ready <= 1'b1;
                @(posedge i_clk);
                while (!eased_if.valid) @(posedge i_clk);
            end
        end
    end

    // offer one progress word after a random gap
    task automatic send_progress(input logic [PROG_W-1:0] p);
        int gap;
        gap = quiet_sides ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            prog_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        prog_if.valid    <= 1'b1;
        prog_if.progress <= p;
        @(posedge i_clk);
        while (!prog_if.ready) @(posedge i_clk);
        sb.note_progress(p);
    endtask

    // stop offering and wait until every eased word is back
    task automatic drain();
        prog_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_eased.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_curve(input logic [3:0] c);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.curve = c;
    endtask

    function automatic logic [PROG_W-1:0] rand_progress();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'd0;
        if (sel == 1) return PROG_W'(ONE);
        if (sel == 2) return PROG_W'(ONE / 2 - 1 + $urandom_range(0, 2));
        if (sel < 5) return PROG_W'($urandom_range(0, 16'hffff));
        return PROG_W'($urandom_range(0, ONE));
    endfunction

    // stimulus
    initial begin
        logic [PROG_W-1:0] edge_vals [7];
        int c;
        edge_vals = '{16'd0, 16'd1, 16'd16383, 16'd16384, 16'd32767, 16'd32768, 16'hffff};
        quiet_sides   = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 4'd0;
        prog_if.valid    = 1'b0;
        prog_if.progress = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes at reset curve, then elastic end points, then bounce in-out
        foreach (edge_vals[i]) send_progress(edge_vals[i]);
        send_progress(16'haaaa);
        send_progress(16'h5555);
        write_curve(CURVE_ELASTIC_INOUT);
        foreach (edge_vals[i]) send_progress(edge_vals[i]);
        write_curve(CURVE_BOUNCE_INOUT);
        foreach (edge_vals[i]) send_progress(edge_vals[i]);

        // random phases over every curve
        for (int ph = 0; ph < 16; ph++) begin
            c = (ph * 7 + 15) % 16;
            write_curve(c[3:0]);
            quiet_sides = (ph % 5 == 2);
            for (int n = 0; n < 70; n++) begin
                if (ph == 3 && n == 10) long_hold_req = 1'b1;
                if (ph == 6 && n == 35) drain();
                send_progress(rand_progress());
            end
        end
        quiet_sides = 1'b0;
        write_curve(CURVE_LINEAR);
        repeat (5) send_progress(rand_progress());
        drain();

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- easing_curve_evaluator.f -----
hw/rtl/ece_pkg.sv
hw/rtl/ece_if.sv
hw/rtl/ece_front.sv
hw/rtl/ece_arith.sv
hw/rtl/ece_combine.sv
hw/rtl/easing_curve_evaluator.sv
verif/tb_easing_curve_evaluator.sv
